FILE: hdl/tfps_pkg.sv
// tfps_pkg: types and constants shared by the feature point selector
// used by tfps_ctrl, tfps_dp and tracking_feature_point_selector
package tfps_pkg;

	localparam int COORD_BITS = 12;
	localparam int IMG_BITS   = 12;
	localparam int CFG_BITS   = 16;
	localparam int CFG_IDX_BITS = 2;

	localparam logic [1:0] MODE_LOAD_CAND = 2'd0;
	localparam logic [1:0] MODE_LOAD_PREV = 2'd1;
	localparam logic [1:0] MODE_SELECT    = 2'd2;
	localparam logic [1:0] MODE_CLEAR     = 2'd3;

	localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SEED   = 2'd2;

	localparam logic [IMG_BITS-1:0] WIDTH_RESET  = 12'd640;
	localparam logic [IMG_BITS-1:0] HEIGHT_RESET = 12'd480;
	localparam logic [15:0] SEED_RESET = 16'd44257;
	localparam logic [15:0] LFSR_TAPS  = 16'hB400;

	localparam logic [1:0] GEO_SQ   = 2'd0;
	localparam logic [1:0] GEO_LINE = 2'd1;
	localparam logic [1:0] GEO_QUAD = 2'd2;

	typedef struct packed {
		logic [1:0]            mode;
		logic [2:0]            select_count;
		logic [COORD_BITS-1:0] x0;
		logic [COORD_BITS-1:0] y0;
		logic [COORD_BITS-1:0] x1;
		logic [COORD_BITS-1:0] y1;
		logic [COORD_BITS-1:0] x2;
		logic [COORD_BITS-1:0] y2;
		logic [7:0]            page;
		logic [3:0]            level;
		logic [15:0]           feature_id;
	} in_word_t;

	typedef struct packed {
		logic       found;
		logic [7:0] index;
	} out_word_t;

	typedef struct packed {
		logic [7:0]  page;
		logic [3:0]  level;
		logic [15:0] id;
	} key_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		key_t                  key;
	} cand_t;

	typedef struct packed {
		logic load_cand;
		logic load_prev;
		logic clear;
		logic latch;
		logic ci_clr;
		logic ci_inc;
		logic pi_clr;
		logic pi_inc;
		logic g_cap;
		logic g_step;
		logic g_score;
		logic pick_cur;
		logic mark_taken;
		logic mark_done;
		logic prev_empty;
		logic n_clr;
		logic n_inc;
		logic lfsr_step;
		logic k_mul;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic ci_end;
		logic pi_end;
		logic step_last;
		logic pdone;
		logic ctaken;
		logic key_eq;
		logic n_zero;
		logic n_eq_k;
		logic hit;
	} sts_t;

endpackage

FILE: hdl/tracking_feature_point_selector.sv
// tracking_feature_point_selector: top level of the feature point selector
// depends on tfps_pkg, tfps_ctrl and tfps_dp
//
//   channel  signals                          word
//   in       in_valid, in_stall, in_word       in_word_t
//   out      out_valid, out_stall, out_word    out_word_t
//   cfg      cfg_wen, cfg_index, cfg_data      16-bit data
//
// loads and clear are taken while idle; a select holds the input until it is done
// geometric select: each stored candidate is read, captured, stepped through
// the single shared multiplier (more steps with three references), then scored
// match select: each previous key not yet done is matched against the stored
// candidates; failing a match, two counting scans make the random pick
// reset clears counts and control; table contents need no clearing
// a finished word waits in the output register while out_stall is high
module tracking_feature_point_selector #(
	parameter int MAX_CANDIDATES = 256,
	parameter int MAX_PREVIOUS   = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  tfps_pkg::in_word_t                in_word,
	output logic                              out_valid,
	input  logic                              out_stall,
	output tfps_pkg::out_word_t               out_word,
	input  logic                              cfg_wen,
	input  logic [tfps_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [tfps_pkg::CFG_BITS-1:0]     cfg_data
);
	import tfps_pkg::*;

	cmd_t cmd;
	sts_t sts;

	tfps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_word   (in_word),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	tfps_dp #(
		.MAX_CANDIDATES (MAX_CANDIDATES),
		.MAX_PREVIOUS   (MAX_PREVIOUS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_word   (in_word),
		.cmd       (cmd),
		.sts       (sts),
		.out_word  (out_word)
	);

endmodule

FILE: hdl/tfps_ctrl.sv
// tfps_ctrl: sequencer for loads, geometric scan, key match and random pick
// depends on tfps_pkg; drives tfps_dp through cmd_t and reads sts_t
module tfps_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  tfps_pkg::in_word_t in_word,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  tfps_pkg::sts_t    sts,
	output tfps_pkg::cmd_t    cmd
);
	import tfps_pkg::*;

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_G_RD  = 5'd1;
	localparam logic [4:0] S_G_WT  = 5'd2;
	localparam logic [4:0] S_G_MUL = 5'd3;
	localparam logic [4:0] S_G_SC  = 5'd4;
	localparam logic [4:0] S_FIN   = 5'd5;
	localparam logic [4:0] S_M_PRD = 5'd6;
	localparam logic [4:0] S_M_PWT = 5'd7;
	localparam logic [4:0] S_M_CRD = 5'd8;
	localparam logic [4:0] S_M_CWT = 5'd9;
	localparam logic [4:0] S_R_CRD = 5'd10;
	localparam logic [4:0] S_R_CWT = 5'd11;
	localparam logic [4:0] S_R_CHK = 5'd12;
	localparam logic [4:0] S_R_MUL = 5'd13;
	localparam logic [4:0] S_S_CRD = 5'd14;
	localparam logic [4:0] S_S_CWT = 5'd15;
	localparam logic [4:0] S_DONE  = 5'd16;

	logic [4:0] state_q, state_d;
	logic       out_valid_q;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (in_word.mode)
						MODE_LOAD_CAND: cmd.load_cand = 1'b1;
						MODE_LOAD_PREV: cmd.load_prev = 1'b1;
						MODE_CLEAR:     cmd.clear = 1'b1;
						default: begin
							cmd.latch  = 1'b1;
							cmd.ci_clr = 1'b1;
							cmd.pi_clr = 1'b1;
							state_d = in_word.select_count[2] ? S_M_PRD : S_G_RD;
						end
					endcase
				end
			end
			S_G_RD: state_d = sts.ci_end ? S_FIN : S_G_WT;
			S_G_WT: begin
				cmd.g_cap = 1'b1;
				state_d = S_G_MUL;
			end
			S_G_MUL: begin
				cmd.g_step = 1'b1;
				if (sts.step_last) state_d = S_G_SC;
			end
			S_G_SC: begin
				cmd.g_score = 1'b1;
				cmd.ci_inc  = 1'b1;
				state_d = S_G_RD;
			end
			S_FIN: begin
				cmd.mark_taken = sts.hit;
				state_d = S_DONE;
			end
			S_M_PRD: begin
				if (sts.pi_end) begin
					cmd.prev_empty = 1'b1;
					cmd.ci_clr = 1'b1;
					cmd.n_clr  = 1'b1;
					state_d = S_R_CRD;
				end else begin
					state_d = S_M_PWT;
				end
			end
			S_M_PWT: begin
				if (sts.pdone) begin
					cmd.pi_inc = 1'b1;
					state_d = S_M_PRD;
				end else begin
					cmd.mark_done = 1'b1;
					cmd.ci_clr = 1'b1;
					state_d = S_M_CRD;
				end
			end
			S_M_CRD: begin
				if (sts.ci_end) begin
					cmd.pi_inc = 1'b1;
					state_d = S_M_PRD;
				end else begin
					state_d = S_M_CWT;
				end
			end
			S_M_CWT: begin
				if (!sts.ctaken && sts.key_eq) begin
					cmd.pick_cur = 1'b1;
					state_d = S_FIN;
				end else begin
					cmd.ci_inc = 1'b1;
					state_d = S_M_CRD;
				end
			end
			S_R_CRD: state_d = sts.ci_end ? S_R_CHK : S_R_CWT;
			S_R_CWT: begin
				cmd.n_inc  = !sts.ctaken;
				cmd.ci_inc = 1'b1;
				state_d = S_R_CRD;
			end
			S_R_CHK: begin
				if (sts.n_zero) begin
					state_d = S_DONE;
				end else begin
					cmd.lfsr_step = 1'b1;
					state_d = S_R_MUL;
				end
			end
			S_R_MUL: begin
				cmd.k_mul  = 1'b1;
				cmd.n_clr  = 1'b1;
				cmd.ci_clr = 1'b1;
				state_d = S_S_CRD;
			end
			S_S_CRD: state_d = sts.ci_end ? S_DONE : S_S_CWT;
			S_S_CWT: begin
				if (!sts.ctaken && sts.n_eq_k) begin
					cmd.pick_cur = 1'b1;
					state_d = S_FIN;
				end else begin
					cmd.n_inc  = !sts.ctaken;
					cmd.ci_inc = 1'b1;
					state_d = S_S_CRD;
				end
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

endmodule

FILE: hdl/tfps_dp.sv
// tfps_dp: tables, config registers, shared multiplier, scoring and lfsr
// depends on tfps_pkg; commanded by tfps_ctrl
module tfps_dp #(
	parameter int MAX_CANDIDATES = 256,
	parameter int MAX_PREVIOUS   = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wen,
	input  logic [tfps_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [tfps_pkg::CFG_BITS-1:0]        cfg_data,
	input  tfps_pkg::in_word_t                   in_word,
	input  tfps_pkg::cmd_t                       cmd,
	output tfps_pkg::sts_t                       sts,
	output tfps_pkg::out_word_t                  out_word
);
	import tfps_pkg::*;

	localparam int CIW = $clog2(MAX_CANDIDATES);
	localparam int CCW = $clog2(MAX_CANDIDATES + 1);
	localparam int PIW = (MAX_PREVIOUS > 1) ? $clog2(MAX_PREVIOUS) : 1;
	localparam int PCW = $clog2(MAX_PREVIOUS + 1);
	localparam int D   = COORD_BITS + 1;
	localparam int PW  = 2 * D;
	localparam int SW  = 2 * D + 2;

	function automatic logic [SW-1:0] mag(input logic signed [SW-1:0] v);
		return v[SW-1] ? SW'(-v) : SW'(v);
	endfunction

	logic [IMG_BITS-1:0] width_q, height_q;
	logic [15:0]         lfsr_q;
	logic [CCW-1:0]      cc_q, ci_q, n_q;
	logic [PCW-1:0]      pc_q, pi_q;

	cand_t cmem [MAX_CANDIDATES];
	logic  tmem [MAX_CANDIDATES];
	key_t  pmem [MAX_PREVIOUS];
	logic  dmem [MAX_PREVIOUS];
	cand_t cd_q;
	logic  tk_q;
	key_t  pd_q;
	logic  pdn_q;

	in_word_t item_q;
	logic [1:0] geo_q;
	logic       cen_q;
	logic signed [D-1:0] v1x_q, v1y_q, v2x_q, v2y_q, dx_q, dy_q;
	logic       elig_q;
	logic [2:0] step_q;
	logic signed [PW-1:0] p_q, e_q, prod;
	logic signed [SW-1:0] cr0_q, cr1_q, cr2_q, comb;
	logic signed [D-1:0]  ma, mb;
	logic [SW-1:0] best_q, score, a0, a1, a2;
	logic          sc_ok, hit_q;
	logic [CIW-1:0] pick_q;
	logic [CCW+15:0] kp_q;
	logic [CCW-1:0]  k_val;

	logic cand_full, prev_full, cwe, pwe, twe, twd, dwe, dwd;
	logic [CIW-1:0] twa;
	logic [PIW-1:0] dwa;
	logic [IMG_BITS-1:0] refx, refy, lo_x, hi_x, lo_y, hi_y;
	logic [IMG_BITS+2:0] w7, h7;
	logic win;

	assign cand_full = (cc_q == CCW'(MAX_CANDIDATES));
	assign prev_full = (pc_q == PCW'(MAX_PREVIOUS));
	assign cwe = cmd.load_cand && !cand_full;
	assign pwe = cmd.load_prev && !prev_full;
	assign twe = cwe || cmd.mark_taken;
	assign twd = cmd.mark_taken;
	assign twa = cmd.mark_taken ? pick_q : cc_q[CIW-1:0];
	assign dwe = pwe || cmd.mark_done;
	assign dwd = cmd.mark_done;
	assign dwa = cmd.mark_done ? pi_q[PIW-1:0] : pc_q[PIW-1:0];

	// tables
	always_ff @(posedge clk) begin
		if (cwe) cmem[cc_q[CIW-1:0]] <= '{x: in_word.x0, y: in_word.y0,
			key: '{page: in_word.page, level: in_word.level, id: in_word.feature_id}};
		cd_q <= cmem[ci_q[CIW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (twe) tmem[twa] <= twd;
		tk_q <= tmem[ci_q[CIW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (pwe) pmem[pc_q[PIW-1:0]] <= '{page: in_word.page, level: in_word.level,
			id: in_word.feature_id};
		pd_q <= pmem[pi_q[PIW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (dwe) dmem[dwa] <= dwd;
		pdn_q <= dmem[pi_q[PIW-1:0]];
	end

	// config, counts, lfsr
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			lfsr_q   <= SEED_RESET;
			cc_q <= '0;
			pc_q <= '0;
			ci_q <= '0;
			pi_q <= '0;
			n_q  <= '0;
			hit_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				unique case (cfg_index)
					CFG_WIDTH:  width_q  <= cfg_data[IMG_BITS-1:0];
					CFG_HEIGHT: height_q <= cfg_data[IMG_BITS-1:0];
					CFG_SEED:   lfsr_q   <= cfg_data;
					default: ;
				endcase
			end else if (cmd.lfsr_step) begin
				lfsr_q <= (lfsr_q >> 1) ^ (lfsr_q[0] ? LFSR_TAPS : 16'd0);
			end
			if (cmd.clear) begin
				cc_q <= '0;
				pc_q <= '0;
			end else begin
				if (cwe) cc_q <= cc_q + 1'b1;
				if (pwe) pc_q <= pc_q + 1'b1;
				if (cmd.prev_empty) pc_q <= '0;
			end
			if (cmd.ci_clr) ci_q <= '0;
			else if (cmd.ci_inc) ci_q <= ci_q + 1'b1;
			if (cmd.pi_clr) pi_q <= '0;
			else if (cmd.pi_inc) pi_q <= pi_q + 1'b1;
			if (cmd.n_clr) n_q <= '0;
			else if (cmd.n_inc) n_q <= n_q + 1'b1;
			if (cmd.latch) hit_q <= 1'b0;
			else if (cmd.pick_cur) hit_q <= 1'b1;
			else if (cmd.g_score && elig_q && sc_ok && score > best_q) hit_q <= 1'b1;
		end
	end

	// window and reference
	assign w7   = ({3'b0, width_q} << 3) - {3'b0, width_q};
	assign h7   = ({3'b0, height_q} << 3) - {3'b0, height_q};
	assign lo_x = width_q >> 3;
	assign lo_y = height_q >> 3;
	assign hi_x = w7[IMG_BITS+2:3];
	assign hi_y = h7[IMG_BITS+2:3];
	assign win  = cd_q.x >= lo_x && cd_q.x <= hi_x && cd_q.y >= lo_y && cd_q.y <= hi_y;
	assign refx = cen_q ? (width_q >> 1) : item_q.x0;
	assign refy = cen_q ? (height_q >> 1) : item_q.y0;

	always_comb begin
		unique case (geo_q)
			GEO_SQ: begin
				ma = step_q[0] ? dy_q : dx_q;
				mb = ma;
			end
			GEO_LINE: begin
				ma = step_q[0] ? dy_q : dx_q;
				mb = step_q[0] ? v1x_q : v1y_q;
			end
			default: begin
				unique case (step_q)
					3'd0: begin ma = v1x_q; mb = v2y_q; end
					3'd1: begin ma = v1y_q; mb = v2x_q; end
					3'd2: begin ma = v1x_q; mb = dy_q; end
					3'd3: begin ma = v1y_q; mb = dx_q; end
					3'd4: begin ma = v2x_q; mb = dy_q; end
					default: begin ma = v2y_q; mb = dx_q; end
				endcase
			end
		endcase
	end

	assign prod = PW'(ma) * PW'(mb);
	assign comb = (geo_q == GEO_SQ) ? SW'(e_q) + SW'(p_q) : SW'(e_q) - SW'(p_q);
	assign sts.step_last = step_q == ((geo_q == GEO_QUAD) ? 3'd6 : 3'd2);

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			item_q <= in_word;
			cen_q  <= (in_word.select_count == 3'd0);
			geo_q  <= (in_word.select_count == 3'd2) ? GEO_LINE :
			          (in_word.select_count == 3'd3) ? GEO_QUAD : GEO_SQ;
			v1x_q <= $signed({1'b0, in_word.x1}) - $signed({1'b0, in_word.x0});
			v1y_q <= $signed({1'b0, in_word.y1}) - $signed({1'b0, in_word.y0});
			v2x_q <= $signed({1'b0, in_word.x2}) - $signed({1'b0, in_word.x0});
			v2y_q <= $signed({1'b0, in_word.y2}) - $signed({1'b0, in_word.y0});
			best_q <= '0;
		end
		if (cmd.g_cap) begin
			dx_q   <= $signed({1'b0, cd_q.x}) - $signed({1'b0, refx});
			dy_q   <= $signed({1'b0, cd_q.y}) - $signed({1'b0, refy});
			elig_q <= !tk_q && win;
			step_q <= '0;
		end
		if (cmd.g_step) begin
			step_q <= step_q + 1'b1;
			if (!sts.step_last) p_q <= prod;
			if (step_q[0]) e_q <= p_q;
			else begin
				unique case (step_q)
					3'd2: cr0_q <= comb;
					3'd4: cr1_q <= comb;
					3'd6: cr2_q <= comb;
					default: ;
				endcase
			end
		end
		if (cmd.g_score && elig_q && sc_ok && score > best_q) begin
			best_q <= score;
			pick_q <= ci_q[CIW-1:0];
		end
		if (cmd.pick_cur) pick_q <= ci_q[CIW-1:0];
		if (cmd.k_mul) kp_q <= n_q * lfsr_q;
		if (cmd.out_load) begin
			out_word.found <= hit_q;
			out_word.index <= hit_q ? 8'(pick_q) : 8'd0;
		end
	end

	// scoring
	assign a0 = mag(cr0_q);
	assign a1 = mag(cr1_q);
	assign a2 = mag(cr2_q);

	always_comb begin
		sc_ok = 1'b1;
		score = '0;
		unique case (geo_q)
			GEO_SQ:   score = SW'(cr0_q);
			GEO_LINE: score = a0;
			default: begin
				if (!cr0_q[SW-1] && !cr1_q[SW-1]) begin
					score = cr2_q[SW-1] ? a1 + a2 : a0 + a2;
				end else if (!cr2_q[SW-1] && (cr0_q[SW-1] || cr0_q == '0)) begin
					score = cr1_q[SW-1] ? a2 + a1 : a0 + a1;
				end else if ((cr1_q[SW-1] || cr1_q == '0) && (cr2_q[SW-1] || cr2_q == '0)) begin
					score = cr0_q[SW-1] ? a2 + a0 : a1 + a0;
				end else begin
					sc_ok = 1'b0;
				end
			end
		endcase
	end

	assign k_val = kp_q[CCW+15:16];

	assign sts.ci_end = (ci_q == cc_q);
	assign sts.pi_end = (pi_q == pc_q);
	assign sts.pdone  = pdn_q;
	assign sts.ctaken = tk_q;
	assign sts.key_eq = (cd_q.key == pd_q);
	assign sts.n_zero = (n_q == '0);
	assign sts.n_eq_k = (n_q == k_val);
	assign sts.hit    = hit_q;

endmodule

FILE: dv/tfps_checker.sv
// tfps_checker: watches the word channels and config port of the selector,
// keeps its own copy of both tables and predicts every select result
// depends on tfps_pkg
module tfps_checker import tfps_pkg::*; #(
	parameter int NCAND = 256,
	parameter int NPREV = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_stall,
	input  in_word_t                in_word,
	input  logic                    out_valid,
	input  logic                    out_stall,
	input  out_word_t               out_word,
	input  logic                    cfg_wen,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]     cfg_data,
	output int                      errors,
	output int                      pending
);

	logic [COORD_BITS-1:0] cand_xs[NCAND];
	logic [COORD_BITS-1:0] cand_ys[NCAND];
	key_t                  cand_keys[NCAND];
	bit                    cand_used[NCAND];
	int                    n_cand;
	key_t                  prev_keys[NPREV];
	bit                    prev_seen[NPREV];
	int                    n_prev;
	logic [15:0]           rng;
	logic [IMG_BITS-1:0]   img_w;
	logic [IMG_BITS-1:0]   img_h;
	out_word_t             expected_words[$];

	assign pending = expected_words.size();

	function automatic longint cross2(longint ax, longint ay, longint bx, longint by);
		return ax * by - ay * bx;
	endfunction

	function automatic longint absl(longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic longint quad_area(longint vx[4], longint vy[4]);
		longint ab, ac, bc;
		int q, r1, r2;
		ab = cross2(vx[1], vy[1], vx[2], vy[2]);
		ac = cross2(vx[1], vy[1], vx[3], vy[3]);
		bc = cross2(vx[2], vy[2], vx[3], vy[3]);
		if (ab >= 0 && ac >= 0) begin
			q = 1;
			if (bc >= 0) begin r1 = 2; r2 = 3; end else begin r1 = 3; r2 = 2; end
		end else if (bc >= 0 && ab <= 0) begin
			q = 2;
			if (ac >= 0) begin r1 = 1; r2 = 3; end else begin r1 = 3; r2 = 1; end
		end else if (ac <= 0 && bc <= 0) begin
			q = 3;
			if (ab >= 0) begin r1 = 1; r2 = 2; end else begin r1 = 2; r2 = 1; end
		end else begin
			return -1;
		end
		return absl(cross2(vx[q], vy[q], vx[r1], vy[r1])) +
		       absl(cross2(vx[r1], vy[r1], vx[r2], vy[r2]));
	endfunction

	task automatic predict_select(input in_word_t w);
		out_word_t res;
		longint px[3], py[3], vx[4], vy[4];
		longint best, s, ccx, ccy, x, y;
		int pick, n, k, j;
		bit hit;
		int unsigned wi, hi;
		px[0] = w.x0; py[0] = w.y0; px[1] = w.x1; py[1] = w.y1; px[2] = w.x2; py[2] = w.y2;
		wi = img_w; hi = img_h;
		hit = 0; pick = 0; best = 0;
		if (w.select_count < 4) begin
			ccx = wi / 2; ccy = hi / 2;
			for (int i = 0; i < n_cand; i++) begin
				x = cand_xs[i]; y = cand_ys[i];
				if (cand_used[i]) continue;
				if (x < wi / 8 || x > wi * 7 / 8 || y < hi / 8 || y > hi * 7 / 8) continue;
				case (w.select_count)
					0: s = (x - ccx) * (x - ccx) + (y - ccy) * (y - ccy);
					1: s = (x - px[0]) * (x - px[0]) + (y - py[0]) * (y - py[0]);
					2: s = absl(cross2(x - px[0], y - py[0], px[1] - px[0], py[1] - py[0]));
					default: begin
						vx[0] = 0; vy[0] = 0;
						vx[1] = px[1] - px[0]; vy[1] = py[1] - py[0];
						vx[2] = px[2] - px[0]; vy[2] = py[2] - py[0];
						vx[3] = x - px[0];     vy[3] = y - py[0];
						s = quad_area(vx, vy);
					end
				endcase
				if (s > best) begin best = s; pick = i; hit = 1; end
			end
		end else begin
			for (int i = 0; i < n_prev && !hit; i++) begin
				if (prev_seen[i]) continue;
				prev_seen[i] = 1;
				for (int c = 0; c < n_cand; c++) begin
					if (!cand_used[c] && cand_keys[c] == prev_keys[i]) begin
						hit = 1; pick = c;
						break;
					end
				end
			end
			if (!hit) begin
				n_prev = 0;
				n = 0;
				for (int i = 0; i < n_cand; i++) if (!cand_used[i]) n++;
				if (n != 0) begin
					rng = rng[0] ? ((rng >> 1) ^ LFSR_TAPS) : (rng >> 1);
					k = int'((longint'(n) * rng) >> 16);
					j = 0;
					for (int i = 0; i < n_cand; i++) begin
						if (cand_used[i]) continue;
						if (j == k) begin hit = 1; pick = i; break; end
						j++;
					end
				end
			end
		end
		if (hit) cand_used[pick] = 1;
		res.found = hit;
		res.index = hit ? pick[7:0] : 8'd0;
		expected_words.push_back(res);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_cand = 0;
			n_prev = 0;
			img_w = WIDTH_RESET;
			img_h = HEIGHT_RESET;
			rng = SEED_RESET;
			errors = 0;
			expected_words.delete();
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					CFG_WIDTH:  img_w = cfg_data[IMG_BITS-1:0];
					CFG_HEIGHT: img_h = cfg_data[IMG_BITS-1:0];
					CFG_SEED:   rng = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected word found=%0d index=%0d",
							out_word.found, out_word.index);
				end else begin
					out_word_t e;
					e = expected_words.pop_front();
					if (e.found !== out_word.found || e.index !== out_word.index) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected found=%0d index=%0d, got found=%0d index=%0d",
								e.found, e.index, out_word.found, out_word.index);
					end
				end
			end
			if (in_valid && !in_stall) begin
				case (in_word.mode)
					MODE_LOAD_CAND: if (n_cand < NCAND) begin
						cand_xs[n_cand] = in_word.x0;
						cand_ys[n_cand] = in_word.y0;
						cand_keys[n_cand] = '{in_word.page, in_word.level, in_word.feature_id};
						cand_used[n_cand] = 0;
						n_cand++;
					end
					MODE_LOAD_PREV: if (n_prev < NPREV) begin
						prev_keys[n_prev] = '{in_word.page, in_word.level, in_word.feature_id};
						prev_seen[n_prev] = 0;
						n_prev++;
					end
					MODE_CLEAR: begin
						n_cand = 0;
						n_prev = 0;
					end
					default: predict_select(in_word);
				endcase
			end
		end
	end

endmodule

FILE: dv/tb_tracking_feature_point_selector.sv
// tb_tracking_feature_point_selector: stimulus, clock, reset and verdict
// depends on tfps_pkg, tracking_feature_point_selector and tfps_checker
module tb_tracking_feature_point_selector;
	import tfps_pkg::*;

	localparam int LIMIT = 4000000;

	logic                    clk = 0;
	logic                    arst_n = 0;
	logic                    in_valid = 0;
	logic                    in_stall;
	in_word_t                in_word = '0;
	logic                    out_valid;
	logic                    out_stall = 0;
	out_word_t               out_word;
	logic                    cfg_wen = 0;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_BITS-1:0]     cfg_data = '0;
	int                      errors;
	int                      pending;
	int                      cycles = 0;
	int                      sent = 0;
	int                      big_sets = 0;
	bit                      quiet = 0;
	int                      cur_w = 640;
	int                      cur_h = 480;
	key_t                    keys_sent[$];

	always #2 clk = ~clk;

	tracking_feature_point_selector u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
		.cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	tfps_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
		.cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// out side: one long hold while words keep coming, then random stalls
	initial begin
		int r;
		wait (sent >= 40);
		@(posedge clk);
		out_stall <= 1;
		repeat (3000) @(posedge clk);
		forever begin
			r = $urandom_range(0, 99);
			out_stall <= (r >= 55);
			if (r < 30) repeat ($urandom_range(20, 80)) @(posedge clk);
			else if (r < 97) repeat ($urandom_range(1, 3)) @(posedge clk);
			else repeat ($urandom_range(30, 200)) @(posedge clk);
		end
	end

	function automatic in_word_t mk(logic [1:0] m, int cnt, int ax, int ay, int bx, int by,
			int qx, int qy, int pg, int lv, int id);
		in_word_t w;
		w.mode = m; w.select_count = 3'(cnt);
		w.x0 = COORD_BITS'(ax); w.y0 = COORD_BITS'(ay);
		w.x1 = COORD_BITS'(bx); w.y1 = COORD_BITS'(by);
		w.x2 = COORD_BITS'(qx); w.y2 = COORD_BITS'(qy);
		w.page = 8'(pg); w.level = 4'(lv); w.feature_id = 16'(id);
		return w;
	endfunction

	task automatic send(input in_word_t w);
		int g;
		bit stl;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1;
		in_word <= w;
		if (w.mode == MODE_LOAD_CAND) keys_sent.push_back('{w.page, w.level, w.feature_id});
		if (keys_sent.size() > 64) void'(keys_sent.pop_front());
		do begin
			@(negedge clk);
			stl = in_stall;
			@(posedge clk);
		end while (stl);
		sent++;
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_cfg(input int wv, input int hv, input int sv);
		cfg_wen <= 1; cfg_index <= CFG_WIDTH; cfg_data <= CFG_BITS'(wv); @(posedge clk);
		cfg_index <= CFG_HEIGHT; cfg_data <= CFG_BITS'(hv); @(posedge clk);
		cfg_index <= CFG_SEED; cfg_data <= CFG_BITS'(sv); @(posedge clk);
		cfg_wen <= 0;
		cur_w = wv; cur_h = hv;
	endtask

	function automatic int coord(bit is_x);
		int lim;
		lim = is_x ? cur_w : cur_h;
		if ($urandom_range(0, 3) == 0) return $urandom_range(0, 4095);
		return $urandom_range(lim / 8, lim * 7 / 8);
	endfunction

	function automatic in_word_t rand_word(logic [1:0] m);
		in_word_t w;
		key_t k;
		int c;
		c = $urandom_range(0, 9);
		c = (c < 8) ? c % 5 : $urandom_range(5, 7);
		w = mk(m, c, coord(1), coord(0), coord(1), coord(0), coord(1), coord(0),
			$urandom_range(0, 3), $urandom_range(0, 1), $urandom_range(0, 3));
		if ($urandom_range(0, 7) == 0) begin
			w.page = 8'($urandom); w.level = 4'($urandom); w.feature_id = 16'($urandom);
		end
		if (m == MODE_LOAD_PREV && keys_sent.size() != 0 && $urandom_range(0, 1)) begin
			k = keys_sent[$urandom_range(0, keys_sent.size() - 1)];
			w.page = k.page; w.level = k.level; w.feature_id = k.id;
		end
		return w;
	endfunction

	task automatic random_set();
		int nc, np, ns;
		if ($urandom_range(0, 29) == 0 && big_sets < 3) begin
			big_sets++;
			nc = 256 + $urandom_range(0, 3);
			np = $urandom_range(0, 4);
			ns = $urandom_range(2, 5);
		end else begin
			nc = $urandom_range(0, 12);
			np = ($urandom_range(0, 29) == 0) ? 66 : $urandom_range(0, 6);
			ns = $urandom_range(1, nc + 3);
		end
		if ($urandom_range(0, 4) != 0) send(mk(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		repeat (nc) send(rand_word(MODE_LOAD_CAND));
		repeat (np) send(rand_word(MODE_LOAD_PREV));
		repeat (ns) begin
			if ($urandom_range(0, 9) == 0) send(rand_word(2'($urandom_range(0, 3))));
			send(rand_word(MODE_SELECT));
		end
	endtask

	initial begin
		int r;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: defaults, extremes, every select kind
		send(mk(MODE_SELECT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send(mk(MODE_SELECT, 4, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send(mk(MODE_LOAD_CAND, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send(mk(MODE_LOAD_CAND, 0, 4095, 4095, 4095, 4095, 4095, 4095, 255, 15, 65535));
		send(mk(MODE_LOAD_CAND, 0, 80, 60, 0, 0, 0, 0, 1, 2, 3));
		send(mk(MODE_LOAD_CAND, 0, 560, 420, 0, 0, 0, 0, 1, 2, 3));
		send(mk(MODE_LOAD_CAND, 0, 320, 240, 0, 0, 0, 0, 7, 1, 9));
		send(mk(MODE_LOAD_CAND, 0, 100, 400, 0, 0, 0, 0, 8, 0, 5));
		send(mk(MODE_LOAD_CAND, 0, 500, 100, 0, 0, 0, 0, 8, 0, 6));
		send(mk(MODE_SELECT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send(mk(MODE_SELECT, 1, 80, 60, 0, 0, 0, 0, 0, 0, 0));
		send(mk(MODE_SELECT, 2, 100, 100, 500, 400, 0, 0, 0, 0, 0));
		send(mk(MODE_SELECT, 3, 320, 240, 320, 240, 4095, 0, 0, 0, 0));
		send(mk(MODE_SELECT, 3, 0, 0, 4095, 0, 0, 4095, 0, 0, 0));
		send(mk(MODE_LOAD_PREV, 0, 0, 0, 0, 0, 0, 0, 9, 9, 9));
		send(mk(MODE_LOAD_PREV, 0, 0, 0, 0, 0, 0, 0, 255, 15, 65535));
		send(mk(MODE_LOAD_PREV, 0, 0, 0, 0, 0, 0, 0, 1, 2, 3));
		send(mk(MODE_SELECT, 4, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send(mk(MODE_SELECT, 7, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send(mk(MODE_SELECT, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send(mk(MODE_SELECT, 6, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send(mk(MODE_SELECT, 4, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send(mk(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send(mk(MODE_SELECT, 2, 4095, 4095, 0, 0, 4095, 4095, 0, 0, 0));
		drain();
		write_cfg(1, 4095, 0);

		while (sent < 1400) begin
			quiet = ($urandom_range(0, 5) == 0);
			random_set();
			r = $urandom_range(0, 7);
			if (r == 0) begin
				drain();
				case ($urandom_range(0, 3))
					0: write_cfg(4095, 1, 65535);
					1: write_cfg(640, 480, 1);
					2: write_cfg(1, 1, 0);
					default: write_cfg($urandom_range(1, 4095), $urandom_range(1, 4095),
						$urandom_range(0, 65535));
				endcase
			end
		end
		drain();
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: sim.f
hdl/tfps_pkg.sv
hdl/tfps_ctrl.sv
hdl/tfps_dp.sv
hdl/tracking_feature_point_selector.sv
dv/tfps_checker.sv
dv/tb_tracking_feature_point_selector.sv
